@@ sv/bsmv_pkg.sv @@
// bsmv_pkg: shared types and constants of the block sparse matvec datapath
// no dependencies
`timescale 1ns / 1ps

package bsmv_pkg;

  // block edge length and fixed-point widths
  localparam int Blk      = 5;
  localparam int ElemW    = 16;
  localparam int ProdW    = 2 * ElemW;
  localparam int AccW     = 48;
  localparam int RowW     = 10;
  localparam int XIdxW    = 13;
  localparam int BColW    = 10;
  localparam int SColW    = 3;

  // row counter limit
  localparam int MaxBlockRows = 1024;
  localparam int NumRowsW     = 11;
  localparam logic [NumRowsW-1:0] NumRowsRst = 11'd1024;
  localparam logic [NumRowsW-1:0] RowLimMax  = NumRowsW'(MaxBlockRows);

  // configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic RegNumBlockRows = 1'b0;

  // item modes; the fourth code is a no-op
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_MUL   = 2'd1,
    MODE_EMPTY = 2'd2
  } mode_e;

  // control from the pipeline to each accumulator lane
  typedef struct packed {
    logic adv;      // pipeline advances this cycle
    logic acc_add;  // product in stage 3 is added
    logic acc_clr;  // row ends, accumulator is cleared
  } lane_ctrl_t;

endpackage

@@ sv/bsmv_ram.sv @@
// bsmv_ram: generic single-port-write, single-port-read RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module bsmv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 5120,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bsmv_lane.sv @@
// bsmv_lane: one block row lane, product register and saturating accumulator
// depends on bsmv_pkg
`timescale 1ns / 1ps

module bsmv_lane
  import bsmv_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctrl_t              ctrl_i,
  input  logic signed [ElemW-1:0] elem_i,
  input  logic [ElemW-1:0]        x_i,
  output logic signed [AccW-1:0]  sum_o
);

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [AccW:0]    sum_wide;
  logic signed [AccW-1:0]  sum_sat;

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      prod_q <= elem_i * $signed(x_i);
    end
  end

  // add with one guard bit, then clamp to the accumulator range
  always_comb begin
    sum_wide = (AccW+1)'(acc_q) + (AccW+1)'(prod_q);
    if (sum_wide[AccW] != sum_wide[AccW-1]) begin
      sum_sat = sum_wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[AccW-1:0];
    end
  end

  // value the row sum takes after this beat
  assign sum_o = ctrl_i.acc_add ? sum_sat : acc_q;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.adv) begin
      if (ctrl_i.acc_clr) begin
        acc_d = '0;
      end else begin
        acc_d = sum_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

@@ sv/block_sparse_matvec_5x5.sv @@
// block_sparse_matvec_5x5: 5x5 block sparse matrix-vector multiply with x store
// a row result is valid once the beat that ends the row has passed through all stages into the result register
// throughput: one beat per cycle; the pipeline stalls only while the result waits
// stages: input register, x store read, product register, accumulate into the result register
// reset: accumulators and row counter zero, num_block_rows 1024, x store undefined
// depends on bsmv_pkg, bsmv_ram, bsmv_lane
`timescale 1ns / 1ps

module block_sparse_matvec_5x5
  import bsmv_pkg::*;
#(
  parameter int MAX_BLOCK_COLS = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              mode_i,
  input  logic [XIdxW-1:0]        x_index_i,
  input  logic signed [ElemW-1:0] x_value_i,
  input  logic [BColW-1:0]        block_col_i,
  input  logic [SColW-1:0]        sub_col_i,
  input  logic signed [ElemW-1:0] elem_r0_i,
  input  logic signed [ElemW-1:0] elem_r1_i,
  input  logic signed [ElemW-1:0] elem_r2_i,
  input  logic signed [ElemW-1:0] elem_r3_i,
  input  logic signed [ElemW-1:0] elem_r4_i,
  input  logic                    row_last_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [RowW-1:0]         row_number_o,
  output logic signed [AccW-1:0]  sum_r0_o,
  output logic signed [AccW-1:0]  sum_r1_o,
  output logic signed [AccW-1:0]  sum_r2_o,
  output logic signed [AccW-1:0]  sum_r3_o,
  output logic signed [AccW-1:0]  sum_r4_o,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrW-1:0]     paddr,
  input  logic [CfgDataW-1:0]     pwdata,
  output logic [CfgDataW-1:0]     prdata,
  output logic                    pready
);

  localparam int StoreDepth = Blk * MAX_BLOCK_COLS;
  localparam int StoreAw    = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int CalcAw     = (StoreAw > XIdxW) ? StoreAw : XIdxW;

  // pipeline advance: everything moves unless a result waits
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // configuration register
  logic [NumRowsW-1:0] num_rows_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegNumBlockRows);
  assign prdata = (paddr[2] == RegNumBlockRows) ?
                  CfgDataW'(num_rows_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= NumRowsRst;
    end else if (cfg_wr) begin
      num_rows_q <= pwdata[NumRowsW-1:0];
    end
  end

  // stage 1: input register
  logic                    s1_valid_q;
  logic [1:0]              s1_mode_q;
  logic [XIdxW-1:0]        s1_xidx_q;
  logic [ElemW-1:0]        s1_xval_q;
  logic [BColW-1:0]        s1_bcol_q;
  logic [SColW-1:0]        s1_scol_q;
  logic signed [ElemW-1:0] s1_elem_q [Blk];
  logic                    s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      s1_mode_q    <= mode_i;
      s1_xidx_q    <= x_index_i;
      s1_xval_q    <= x_value_i;
      s1_bcol_q    <= block_col_i;
      s1_scol_q    <= sub_col_i;
      s1_elem_q[0] <= elem_r0_i;
      s1_elem_q[1] <= elem_r1_i;
      s1_elem_q[2] <= elem_r2_i;
      s1_elem_q[3] <= elem_r3_i;
      s1_elem_q[4] <= elem_r4_i;
      s1_last_q    <= row_last_i;
    end
  end

  // x store addressing: 5*block_col + sub_col, range checked
  logic [CalcAw-1:0] ld_addr, rd_addr;
  logic              ld_ok, rd_ok, is_load, is_mul, is_empty;
  logic              ram_we, ram_re;
  logic [ElemW-1:0]  ram_rdata;

  assign is_load  = s1_valid_q && (s1_mode_q == MODE_LOAD);
  assign is_mul   = s1_valid_q && (s1_mode_q == MODE_MUL);
  assign is_empty = s1_valid_q && (s1_mode_q == MODE_EMPTY);

  assign ld_addr = CalcAw'(s1_xidx_q);
  assign rd_addr = (CalcAw'(s1_bcol_q) << 2) + CalcAw'(s1_bcol_q) + CalcAw'(s1_scol_q);
  assign ld_ok   = (32'(ld_addr) < 32'(StoreDepth));
  assign rd_ok   = (s1_scol_q < SColW'(Blk)) && (32'(rd_addr) < 32'(StoreDepth));

  assign ram_we = en && is_load && ld_ok;
  assign ram_re = en && is_mul && rd_ok;

  bsmv_ram #(
    .WIDTH (ElemW),
    .DEPTH (StoreDepth)
  ) u_xstore (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ld_addr[StoreAw-1:0]),
    .wdata_i (s1_xval_q),
    .re_i    (ram_re),
    .raddr_i (rd_addr[StoreAw-1:0]),
    .rdata_o (ram_rdata)
  );

  // stage 2: x entry arrives from the store
  logic                    s2_valid_q, s2_add_q, s2_emit_q;
  logic signed [ElemW-1:0] s2_elem_q [Blk];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_add_q   <= 1'b0;
      s2_emit_q  <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
      s2_add_q   <= is_mul && rd_ok;
      s2_emit_q  <= (is_mul && s1_last_q) || is_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_elem_q <= s1_elem_q;
    end
  end

  // stage 3: products registered inside the lanes
  logic s3_valid_q, s3_add_q, s3_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s3_add_q   <= 1'b0;
      s3_emit_q  <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
      s3_add_q   <= s2_add_q;
      s3_emit_q  <= s2_emit_q;
    end
  end

  lane_ctrl_t             lane_ctrl;
  logic signed [AccW-1:0] lane_sum [Blk];
  logic                   emit;

  assign emit              = en && s3_valid_q && s3_emit_q;
  assign lane_ctrl.adv     = en;
  assign lane_ctrl.acc_add = s3_valid_q && s3_add_q;
  assign lane_ctrl.acc_clr = s3_valid_q && s3_emit_q;

  for (genvar r = 0; r < Blk; r++) begin : g_lane
    bsmv_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .elem_i (s2_elem_q[r]),
      .x_i    (ram_rdata),
      .sum_o  (lane_sum[r])
    );
  end

  // row counter, wraps at min(num_block_rows, max rows), zero acts as one
  logic [RowW-1:0]     row_cnt_q, row_cnt_d;
  logic [NumRowsW-1:0] row_lim, row_inc;

  always_comb begin
    if (num_rows_q == '0) begin
      row_lim = NumRowsW'(1);
    end else if (num_rows_q > RowLimMax) begin
      row_lim = RowLimMax;
    end else begin
      row_lim = num_rows_q;
    end
    row_inc   = NumRowsW'(row_cnt_q) + NumRowsW'(1);
    row_cnt_d = row_cnt_q;
    if (emit) begin
      row_cnt_d = (row_inc >= row_lim) ? '0 : row_inc[RowW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
    end else begin
      row_cnt_q <= row_cnt_d;
    end
  end

  // result register
  logic                   out_valid_q;
  logic [RowW-1:0]        out_row_q;
  logic signed [AccW-1:0] out_sum_q [Blk];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s3_valid_q && s3_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_row_q <= row_cnt_q;
      out_sum_q <= lane_sum;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_number_o = out_row_q;
  assign sum_r0_o     = out_sum_q[0];
  assign sum_r1_o     = out_sum_q[1];
  assign sum_r2_o     = out_sum_q[2];
  assign sum_r3_o     = out_sum_q[3];
  assign sum_r4_o     = out_sum_q[4];

  // a result beat only follows a row end in the accumulate stage
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s3_valid_q && s3_emit_q))
    else $error("result raised without a row end");

  // the store never reads and writes in the same cycle
  a_ram_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("x store read and write collide");

  // row counter steps by one or wraps on each emitted row
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (row_cnt_q == '0) || (row_cnt_q == RowW'($past(row_cnt_q) + RowW'(1))))
    else $error("row counter skipped");

  // a held result freezes the whole pipeline
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s3_valid_q) && $stable(s2_valid_q) && $stable(row_cnt_q))
    else $error("pipeline moved during a stall");

endmodule
